[rtl/cu_pkg.sv]
// ----------------------------------------------------------------------------
// cu_pkg: shared definitions for the combination unranking block
// Widths, limits, configuration register indexes and the command and status
// bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package cu_pkg;

    localparam int MAX_SET_SIZE = 64;
    localparam int MAX_CHOOSE   = 16;

    localparam int SET_W    = $clog2(MAX_SET_SIZE + 1);
    localparam int CHOOSE_W = $clog2(MAX_CHOOSE + 1);
    localparam int RANK_W   = 49;
    localparam int ELEM_W   = 6;

    // The binomial table is addressed as {m, r}, with m up to MAX_SET_SIZE
    // and r up to MAX_CHOOSE.
    localparam int TAB_AW    = SET_W + CHOOSE_W;
    localparam int TAB_DEPTH = (MAX_SET_SIZE + 1) << CHOOSE_W;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;

    localparam logic [CFG_IDX_W-1:0] CFG_SET_SIZE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHOOSE_COUNT = 2'd1;

    localparam logic [SET_W-1:0] SET_SIZE_RESET     = SET_W'(64);
    localparam logic [CHOOSE_W-1:0] CHOOSE_COUNT_RESET = CHOOSE_W'(1);

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic fill_step;  // write one table entry and advance the fill counters
        logic load;       // capture the rank and the clamped configuration
        logic rd_total;   // read C(n, k)
        logic rd_cand;    // read C(n - x - 1, k - i - 1)
        logic skip;       // subtract the coefficient and move to the next candidate
        logic emit_elem;  // load the output register with the current element
        logic emit_err;   // load the output register with the error word
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic fill_last;
        logic cfg_bad;
        logic total_over;
        logic cand_more;
        logic cand_take;
        logic last_elem;
        logic out_free;
    } stat_t;

endpackage

`default_nettype wire

[rtl/cu_ram.sv]
// ----------------------------------------------------------------------------
// cu_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module cu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

[rtl/cu_datapath.sv]
// ----------------------------------------------------------------------------
// cu_datapath: registers, binomial table and arithmetic of the unranker
// Holds the configuration, the remaining rank, the candidate and element
// counters, the Pascal row used to fill the table, and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module cu_datapath (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire cu_pkg::cmd_t                  cmd,
    output cu_pkg::stat_t                      stat,
    input  wire logic                          cfg_write,
    input  wire logic [cu_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [cu_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic [cu_pkg::RANK_W-1:0]     rank,
    input  wire logic                          out_stall,
    output logic                               out_valid,
    output logic [cu_pkg::ELEM_W-1:0]          element_value,
    output logic                               last_element,
    output logic                               rank_error
);

    import cu_pkg::*;

    logic [SET_W-1:0]    set_size_reg;
    logic [CHOOSE_W-1:0] choose_count_reg;

    logic [SET_W-1:0]    n_reg;
    logic [CHOOSE_W-1:0] k_reg;
    logic [RANK_W-1:0]   left_reg;
    logic [SET_W-1:0]    x_reg;
    logic [CHOOSE_W-1:0] i_reg;

    logic [SET_W-1:0]    fill_m_reg;
    logic [CHOOSE_W-1:0] fill_r_reg;
    logic [RANK_W-1:0]   row_reg [MAX_CHOOSE + 1];

    logic                out_valid_reg;
    logic [ELEM_W-1:0]   element_value_reg;
    logic                last_element_reg;
    logic                rank_error_reg;

    logic [SET_W-1:0]    n_clamp;
    logic [CHOOSE_W-1:0] k_clamp;
    logic [RANK_W-1:0]   fill_sum;
    logic [TAB_AW-1:0]   waddr;
    logic [TAB_AW-1:0]   raddr;
    logic [RANK_W-1:0]   rdata;
    logic [SET_W-1:0]    cand_m;
    logic [CHOOSE_W-1:0] cand_r;
    logic [SET_W:0]      x_plus;
    logic [CHOOSE_W-1:0] i_plus;
    logic                out_free;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_size_reg     <= SET_SIZE_RESET;
            choose_count_reg <= CHOOSE_COUNT_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_SET_SIZE:     set_size_reg     <= cfg_data[SET_W-1:0];
                CFG_CHOOSE_COUNT: choose_count_reg <= cfg_data[CHOOSE_W-1:0];
                default:          ;
            endcase
        end
    end

    assign n_clamp = (set_size_reg > SET_W'(MAX_SET_SIZE)) ?
                     SET_W'(MAX_SET_SIZE) : set_size_reg;
    assign k_clamp = (choose_count_reg > CHOOSE_W'(MAX_CHOOSE)) ?
                     CHOOSE_W'(MAX_CHOOSE) : choose_count_reg;

    // Table fill: the row shift line holds the previous Pascal row with the
    // highest column at the head, so each step sees C(m-1, r) and C(m-1, r-1).
    assign fill_sum = (fill_r_reg == '0) ? RANK_W'(1) : row_reg[0] + row_reg[1];
    assign waddr    = {fill_m_reg, fill_r_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_m_reg <= '0;
            fill_r_reg <= CHOOSE_W'(MAX_CHOOSE);
            for (int j = 0; j <= MAX_CHOOSE; j++)
            begin
                row_reg[j] <= '0;
            end
        end
        else if (cmd.fill_step)
        begin
            for (int j = 0; j < MAX_CHOOSE; j++)
            begin
                row_reg[j] <= row_reg[j + 1];
            end
            row_reg[MAX_CHOOSE] <= fill_sum;
            if (fill_r_reg == '0)
            begin
                fill_r_reg <= CHOOSE_W'(MAX_CHOOSE);
                fill_m_reg <= fill_m_reg + SET_W'(1);
            end
            else
            begin
                fill_r_reg <= fill_r_reg - CHOOSE_W'(1);
            end
        end
    end

    assign cand_m = n_reg - x_reg - SET_W'(1);
    assign cand_r = k_reg - i_reg - CHOOSE_W'(1);
    assign raddr  = cmd.rd_cand ? {cand_m, cand_r} : {n_reg, k_reg};

    cu_ram #(
        .WIDTH (RANK_W),
        .DEPTH (TAB_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (cmd.fill_step),
        .waddr (waddr),
        .wdata (fill_sum),
        .re    (cmd.rd_total | cmd.rd_cand),
        .raddr (raddr),
        .rdata (rdata)
    );

    // Rank walk registers.
    assign x_plus = {1'b0, x_reg} + (SET_W + 1)'(1);
    assign i_plus = i_reg + CHOOSE_W'(1);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            n_reg    <= n_clamp;
            k_reg    <= k_clamp;
            left_reg <= rank;
            x_reg    <= '0;
            i_reg    <= '0;
        end
        else if (cmd.skip)
        begin
            left_reg <= left_reg - rdata;
            x_reg    <= x_plus[SET_W-1:0];
        end
        else if (cmd.emit_elem)
        begin
            x_reg <= x_plus[SET_W-1:0];
            i_reg <= i_plus;
        end
    end

    // Output register.
    assign out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit_elem || cmd.emit_err)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_elem)
        begin
            element_value_reg <= x_reg[ELEM_W-1:0];
            last_element_reg  <= (i_plus == k_reg);
            rank_error_reg    <= 1'b0;
        end
        else if (cmd.emit_err)
        begin
            element_value_reg <= '0;
            last_element_reg  <= 1'b1;
            rank_error_reg    <= 1'b1;
        end
    end

    assign out_valid     = out_valid_reg;
    assign element_value = element_value_reg;
    assign last_element  = last_element_reg;
    assign rank_error    = rank_error_reg;

    always_comb
    begin
        stat.fill_last  = (fill_m_reg == SET_W'(MAX_SET_SIZE)) && (fill_r_reg == '0);
        stat.cfg_bad    = (k_reg == '0) || (SET_W'(k_reg) > n_reg);
        stat.total_over = (left_reg >= rdata);
        stat.cand_more  = (x_plus < {1'b0, n_reg});
        stat.cand_take  = (rdata <= left_reg);
        stat.last_elem  = (i_plus == k_reg);
        stat.out_free   = out_free;
    end

    // The output register is loaded only when its word has been taken.
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit_elem || cmd.emit_err) |-> out_free)
        else $error("output register loaded while its word is still held");

    // A skip never drives the remaining rank below zero.
    a_skip_fits: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.skip |-> (rdata <= left_reg))
        else $error("coefficient subtracted exceeds remaining rank");

    // Every element sent lies inside the set.
    a_elem_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_elem |-> (x_reg < n_reg))
        else $error("element outside the set");

endmodule

`default_nettype wire

[rtl/cu_ctrl.sv]
// ----------------------------------------------------------------------------
// cu_ctrl: sequencing state machine of the unranker
// Runs the table fill after reset, then walks candidates for each valid rank
// and hands elements to the output register, or an error word otherwise.
// ----------------------------------------------------------------------------
`default_nettype none

module cu_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_stall,
    input  wire cu_pkg::stat_t stat,
    output cu_pkg::cmd_t       cmd
);

    import cu_pkg::*;

    typedef enum logic [2:0] {
        S_FILL,
        S_IDLE,
        S_START,
        S_CHECK,
        S_CAND,
        S_CMP,
        S_EMIT,
        S_ERR
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   in_stall_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_FILL:
            begin
                cmd.fill_step = 1'b1;
                if (stat.fill_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid && !in_stall_reg)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_START;
                end
            end
            S_START:
            begin
                if (stat.cfg_bad)
                begin
                    state_next = S_ERR;
                end
                else
                begin
                    cmd.rd_total = 1'b1;
                    state_next   = S_CHECK;
                end
            end
            S_CHECK:
            begin
                state_next = stat.total_over ? S_ERR : S_CAND;
            end
            S_CAND:
            begin
                if (stat.cand_more)
                begin
                    cmd.rd_cand = 1'b1;
                    state_next  = S_CMP;
                end
                else
                begin
                    state_next = S_EMIT;
                end
            end
            S_CMP:
            begin
                if (stat.cand_take)
                begin
                    cmd.skip   = 1'b1;
                    state_next = S_CAND;
                end
                else
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit_elem = 1'b1;
                    state_next    = stat.last_elem ? S_IDLE : S_CAND;
                end
            end
            S_ERR:
            begin
                if (stat.out_free)
                begin
                    cmd.emit_err = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_FILL;
            in_stall_reg <= 1'b1;
        end
        else
        begin
            state_reg    <= state_next;
            in_stall_reg <= (state_next != S_IDLE);
        end
    end

    assign in_stall = in_stall_reg;

    // Once the table is filled it is never filled again.
    a_fill_once: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_FILL) |=> (state_reg != S_FILL))
        else $error("table fill restarted");

    // The input is held off for as long as a rank is in work.
    a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> in_stall_reg)
        else $error("input open while a rank is in work");

endmodule

`default_nettype wire

[rtl/combination_unrank.sv]
// ----------------------------------------------------------------------------
// combination_unrank: lexicographic combination unranking
// Turns a rank into the k-element subset of {0..n-1} at that position in
// lexicographic order and sends its elements in ascending order.
// ----------------------------------------------------------------------------
//
// Usage
//   Configuration: write set_size (index 0) and choose_count (index 1) on the
//   cfg channel while the block is idle; cfg_ready is always high. Reset gives
//   set_size = 64 and choose_count = 1. Values above 64 and 16 are clamped.
//   Input: one rank word per item, accepted when in_valid is high and
//   in_stall is low. Output: k words per rank, one element each, with
//   last_element set on the final one. A rank of C(n,k) or more, a
//   choose_count of zero, or one above set_size gives one word with
//   element_value = 0 and both last_element and rank_error set.
//   After reset the block fills its binomial table from Pascal's rule, one
//   entry a cycle, 65 x 17 = 1105 entries in all, with in_stall held high;
//   configuration writes are taken during that time.
//   Timing: one rank at a time. Each rank runs a table read and compare
//   loop over the candidate positions, skipping some and emitting each
//   element; error words are sent without the candidate walk. The next
//   rank can be accepted in the cycle after the last word is loaded.
//   The last word sits in the output register while the next rank is
//   accepted. When the receiver stalls, the walk holds at the next element
//   until the output register frees up.
//
// ----------------------------------------------------------------------------
`default_nettype none

module combination_unrank (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [cu_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [cu_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [cu_pkg::RANK_W-1:0]     rank,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [cu_pkg::ELEM_W-1:0]          element_value,
    output logic                               last_element,
    output logic                               rank_error
);

    import cu_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    // Registers are plain flops, so a write can land in any cycle.
    assign cfg_ready = 1'b1;

    cu_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    cu_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .cfg_write     (cfg_valid && cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .rank          (rank),
        .out_stall     (out_stall),
        .out_valid     (out_valid),
        .element_value (element_value),
        .last_element  (last_element),
        .rank_error    (rank_error)
    );

endmodule

`default_nettype wire

[test/combination_unrank_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// combination_unrank_checker: predicts and checks the unranking block
// Mirrors the configuration registers from the write channel, expands every
// accepted rank into the words it must produce, and compares each accepted
// output word with the oldest one still owed.
// ----------------------------------------------------------------------------

module combination_unrank_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [cu_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cu_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                          in_valid,
    input  logic                          in_stall,
    input  logic [cu_pkg::RANK_W-1:0]     rank,
    input  logic                          out_valid,
    input  logic                          out_stall,
    input  logic [cu_pkg::ELEM_W-1:0]     element_value,
    input  logic                          last_element,
    input  logic                          rank_error,
    input  logic                          run_done,
    output int                            fail_count,
    output int                            words_owed,
    output longint unsigned               comb_total
);

    import cu_pkg::*;

    typedef struct packed {
        logic [ELEM_W-1:0] value;
        logic              last;
        logic              err;
    } elem_word_t;

    elem_word_t owed_words[$];

    logic [SET_W-1:0]    set_size_q;
    logic [CHOOSE_W-1:0] choose_q;
    int unsigned         n_eff;
    int unsigned         k_eff;
    int                  fails = 0;
    int                  owed = 0;
    logic                closed = 1'b0;

    assign fail_count = fails;
    assign words_owed = owed;

    // Exact binomial coefficient: multiply, then divide exactly, step by step.
    function automatic longint unsigned choose_exact(int unsigned m, int unsigned r);
        longint unsigned acc;
        int unsigned     j;
        int unsigned     rr;
        acc = 1;
        rr  = r;
        if (r > m)
            return 0;
        if (r == 0 || r == m)
            return 1;
        if (rr > m - rr)
            rr = m - rr;
        for (j = 1; j <= rr; j++)
        begin
            acc = acc * (m - j + 1);
            acc = acc / j;
        end
        return acc;
    endfunction

    always_comb
    begin
        n_eff = (set_size_q > MAX_SET_SIZE) ? MAX_SET_SIZE : set_size_q;
        k_eff = (choose_q > MAX_CHOOSE) ? MAX_CHOOSE : choose_q;
        if (k_eff == 0 || k_eff > n_eff)
            comb_total = 0;
        else
            comb_total = choose_exact(n_eff, k_eff);
    end

    // Walks candidates upward, queueing a word per element, or one error word.
    function automatic void expand_rank(logic [RANK_W-1:0] r);
        longint unsigned left;
        longint unsigned c;
        int unsigned     x;
        int unsigned     i;
        elem_word_t      w;
        left = r;
        x    = 0;
        if (left >= comb_total)
        begin
            w.value = '0;
            w.last  = 1'b1;
            w.err   = 1'b1;
            owed_words.push_back(w);
            return;
        end
        for (i = 0; i < k_eff; i++)
        begin
            while (x + 1 < n_eff)
            begin
                c = choose_exact(n_eff - x - 1, k_eff - i - 1);
                if (c > left)
                    break;
                left = left - c;
                x++;
            end
            w.value = ELEM_W'(x);
            w.last  = (i + 1 == k_eff);
            w.err   = 1'b0;
            owed_words.push_back(w);
            x++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_size_q <= SET_SIZE_RESET;
            choose_q   <= CHOOSE_COUNT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == CFG_SET_SIZE)
                set_size_q <= cfg_data[SET_W-1:0];
            else if (cfg_index == CFG_CHOOSE_COUNT)
                choose_q <= cfg_data[CHOOSE_W-1:0];
        end
    end

    always @(posedge clk)
    begin : watch
        elem_word_t want;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                expand_rank(rank);
            if (out_valid && !out_stall)
            begin
                if (owed_words.size() == 0)
                begin
                    fails++;
                    if (fails <= 10)
                        $display("unexpected word: value %0d last %0b error %0b",
                                 element_value, last_element, rank_error);
                end
                else
                begin
                    want = owed_words.pop_front();
                    if (element_value !== want.value || last_element !== want.last ||
                        rank_error !== want.err)
                    begin
                        fails++;
                        if (fails <= 10)
                            $display("word mismatch: expected value %0d last %0b error %0b,",
                                     want.value, want.last, want.err,
                                     " got value %0d last %0b error %0b",
                                     element_value, last_element, rank_error);
                    end
                end
            end
            if (run_done && !closed)
            begin
                closed = 1'b1;
                if (owed_words.size() != 0)
                begin
                    fails += owed_words.size();
                    $display("%0d expected words never arrived", owed_words.size());
                end
            end
        end
        owed = owed_words.size();
    end

endmodule

[test/combination_unrank_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// combination_unrank_test: top level of the unranking testbench
// Drives configuration writes and ranks into the block, stalls its output at
// random, and leaves prediction and comparison to the checker beside it.
// ----------------------------------------------------------------------------

module combination_unrank_test;
    import cu_pkg::*;

    // Writes to this index should be ignored by the block.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    // The slowest legal run is roughly 350 ranks of sixteen words, each word
    // waiting out the longest random receiver stall, plus the walk itself
    // and the table fill after reset; the limit is set above that.
    localparam int RUN_LIMIT   = 600_000;
    localparam int HOLD_CYCLES = 300;
    localparam int IDLE_GAP    = 4;
    localparam int END_CYCLES  = 200;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_stall;
    logic [RANK_W-1:0]     rank;
    logic                  out_valid;
    logic                  out_stall;
    logic [ELEM_W-1:0]     element_value;
    logic                  last_element;
    logic                  rank_error;
    logic                  run_done;

    int              fail_count;
    int              words_owed;
    longint unsigned comb_total;
    int              cycle_count = 0;

    // Shared between the stimulus and the receiver: whether both sides idle
    // at random, and a one-shot request for a long receiver hold-off.
    logic idle_on      = 1'b1;
    logic hold_pending = 1'b0;

    combination_unrank u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .rank          (rank),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .element_value (element_value),
        .last_element  (last_element),
        .rank_error    (rank_error)
    );

    combination_unrank_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .rank          (rank),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .element_value (element_value),
        .last_element  (last_element),
        .rank_error    (rank_error),
        .run_done      (run_done),
        .fail_count    (fail_count),
        .words_owed    (words_owed),
        .comb_total    (comb_total)
    );

    always #10 clk = ~clk;

    // A run that hangs anywhere ends here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // Receiver. Before every word it stalls, if idling is on, for a random
    // number of cycles, or for a long stretch when a hold-off has been
    // requested, so that the block backs up while the sender keeps offering
    // ranks. Stall is changed only on falling edges, and only once per edge.
    initial
    begin : receiver
        int wait_n;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            wait_n = idle_on ? $urandom_range(0, 10) : 0;
            if (hold_pending)
            begin
                wait_n       = HOLD_CYCLES;
                hold_pending = 1'b0;
            end
            if (wait_n > 0)
            begin
                out_stall <= 1'b1;
                repeat (wait_n) @(negedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
        end
    end

    // Offers one rank, after a random gap if idling is on, and returns on the
    // falling edge that follows its acceptance. Valid stays high on return, so a
    // rank that follows without a gap is presented without a dip in valid.
    task automatic send_rank(input logic [RANK_W-1:0] r);
        int gap;
        gap = idle_on ? $urandom_range(0, 10) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        rank     <= r;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    // One register write; valid is left high so that writes can follow back
    // to back. The caller lowers it once the last write is done.
    task automatic cfg_put(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Waits until every owed word has been seen, then lets the block rest so
    // that it is idle for what comes next.
    task automatic drain;
        in_valid <= 1'b0;
        @(negedge clk);
        while (words_owed != 0)
            @(negedge clk);
        repeat (IDLE_GAP) @(negedge clk);
    endtask

    // Moves the block to a new set size and choose count once it is idle.
    // The spare index can be poked first to show that it has no effect.
    task automatic new_setting(input logic [CFG_DATA_W-1:0] n,
                               input logic [CFG_DATA_W-1:0] k,
                               input logic poke_spare);
        drain();
        if (poke_spare)
            cfg_put(CFG_SPARE, '1);
        cfg_put(CFG_SET_SIZE, n);
        cfg_put(CFG_CHOOSE_COUNT, k);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    // Mostly ranks inside the valid range, with weight on its two ends, and
    // some beyond it. With no valid combination at all every rank is noise.
    function automatic logic [RANK_W-1:0] pick_rank(input longint unsigned total);
        longint unsigned wide;
        int unsigned     sel;
        wide = {$urandom, $urandom};
        sel  = $urandom_range(0, 99);
        if (total == 0 || sel >= 92)
            return RANK_W'(wide);
        if (sel < 70)
            return RANK_W'(wide % total);
        if (sel < 78)
            return RANK_W'(total - 1);
        if (sel < 84)
            return '0;
        return RANK_W'(total + $urandom_range(0, 3));
    endfunction

    initial
    begin : stimulus
        logic [CFG_DATA_W-1:0] n_pick;
        logic [CFG_DATA_W-1:0] k_pick;
        int                    count;
        int                    sel;

        rst_n     = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        in_valid  = 1'b0;
        rank      = '0;
        run_done  = 1'b0;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part. The reset setting, 64 choose 1, first: both ends of
        // the range, the first rank past it, and the largest rank of all.
        // The block is still filling its table, so the first word waits.
        send_rank('0);
        send_rank(RANK_W'(63));
        send_rank(RANK_W'(64));
        send_rank('1);

        // The largest setting: sixteen words per rank, and its last valid
        // rank uses the top bit of the field.
        new_setting(7'd64, 7'd16, 1'b0);
        send_rank('0);
        send_rank(RANK_W'(comb_total - 1));
        send_rank(RANK_W'(comb_total));
        send_rank('1);

        // A small case that is easy to check by hand, with a write to the
        // unused register index in front of it.
        new_setting(7'd5, 7'd3, 1'b1);
        send_rank('0);
        send_rank(RANK_W'(4));
        send_rank(RANK_W'(9));
        send_rank(RANK_W'(10));

        // A choose count of zero is an error for any rank.
        new_setting(7'd10, 7'd0, 1'b0);
        send_rank('0);

        // A choose count above the set size has no combinations, which also
        // covers set sizes of zero.
        new_setting(7'd3, 7'd5, 1'b0);
        send_rank(RANK_W'(1));
        new_setting(7'd0, 7'd1, 1'b0);
        send_rank('0);

        // One item out of one: a single valid rank.
        new_setting(7'd1, 7'd1, 1'b0);
        send_rank('0);
        send_rank(RANK_W'(1));

        // Register values beyond the limits are clamped to 64 and 16.
        new_setting(7'd127, 7'd31, 1'b0);
        send_rank('0);
        send_rank(RANK_W'(comb_total - 1));

        // A set of two, taking both items.
        new_setting(7'd2, 7'd2, 1'b0);
        send_rank('0);
        send_rank(RANK_W'(1));

        // Random part, in phases with a fresh setting each. The first two
        // phases pin the largest and the smallest settings. Every fourth phase,
        // starting with the second, runs without idling, as does the fourth, which
        // also holds off the receiver for a long stretch while ranks keep coming.
        for (int ph = 0; ph < 11; ph++)
        begin
            count = 30;
            if (ph == 0)
            begin
                n_pick = 7'd64;
                k_pick = 7'd16;
            end
            else if (ph == 1)
            begin
                n_pick = 7'd2;
                k_pick = 7'd1;
            end
            else
            begin
                sel = $urandom_range(0, 9);
                if (sel == 0)
                begin
                    n_pick = CFG_DATA_W'($urandom_range(65, 127));
                    k_pick = CFG_DATA_W'($urandom_range(17, 31));
                end
                else if (sel == 1)
                begin
                    // A setting with no valid combination: keep it short.
                    n_pick = CFG_DATA_W'($urandom_range(2, 15));
                    k_pick = $urandom_range(0, 1) ? '0 : n_pick + 1'b1;
                    count  = 8;
                end
                else
                begin
                    n_pick = CFG_DATA_W'($urandom_range(2, 64));
                    k_pick = CFG_DATA_W'($urandom_range(1, (n_pick < 16) ? n_pick : 16));
                end
            end
            new_setting(n_pick, k_pick, 1'b0);
            idle_on = !(ph % 4 == 1 || ph == 3);
            if (ph == 3)
                hold_pending = 1'b1;
            for (int i = 0; i < count; i++)
                send_rank(pick_rank(comb_total));
        end
        idle_on = 1'b1;

        // Let every owed word arrive, then watch for stray ones a while
        // before the checker closes its books.
        drain();
        repeat (END_CYCLES) @(negedge clk);
        run_done <= 1'b1;
        @(negedge clk);
        @(negedge clk);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

[combination_unrank.f]
rtl/cu_pkg.sv
rtl/cu_ram.sv
rtl/cu_datapath.sv
rtl/cu_ctrl.sv
rtl/combination_unrank.sv
test/combination_unrank_checker.sv
test/combination_unrank_test.sv
